// File: rtl/hues_pkg.sv
// ----------------------------------------------------------------------------
// hues_pkg
// Shared types, character codes and escape helpers for the escape stream.
// ----------------------------------------------------------------------------
package hues_pkg;

	// escape_mode register codes
	localparam logic [1:0] MODE_ATTR   = 2'd0;
	localparam logic [1:0] MODE_ENTITY = 2'd1;
	localparam logic [1:0] MODE_URL    = 2'd2;

	// run kinds chosen at intake
	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_ENT  = 2'd1;
	localparam logic [1:0] KIND_URL  = 2'd2;

	// ASCII codes used by the escapes
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_LO  = 8'h61;

	typedef logic [2:0] run_idx_t;

	// one classified input byte waiting for expansion
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       eos;
		logic       sane;
	} run_item_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

	function automatic logic is_html_special(input logic [7:0] b);
		return b inside {CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SLASH};
	endfunction

	// lower-case hex digit of one nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] n8;
		n8 = {4'b0000, n};
		return (n < 4'd10) ? (CH_ZERO + n8) : (CH_A_LO - 8'd10 + n8);
	endfunction

	function automatic run_idx_t run_len(input logic [1:0] kind);
		case (kind)
			KIND_ENT: return 3'd6;
			KIND_URL: return 3'd3;
			default:  return 3'd1;
		endcase
	endfunction

	// byte at position idx of the escaped run
	function automatic logic [7:0] run_char(input logic [1:0] kind, input logic [7:0] b,
		input run_idx_t idx);
		logic [7:0] c;
		c = b;
		case (kind)
			KIND_URL: begin
				case (idx)
					3'd0:    c = CH_PCT;
					3'd1:    c = hex_digit(b[7:4]);
					default: c = hex_digit(b[3:0]);
				endcase
			end
			KIND_ENT: begin
				case (idx)
					3'd0:    c = CH_AMP;
					3'd1:    c = CH_HASH;
					3'd2:    c = CH_X;
					3'd3:    c = hex_digit(b[7:4]);
					3'd4:    c = hex_digit(b[3:0]);
					default: c = CH_SEMI;
				endcase
			end
			default: c = b;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/hues_emit.sv
// ----------------------------------------------------------------------------
// hues_emit
// Holds one classified byte and walks its escaped run into the output
// register, one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module hues_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  hues_pkg::run_item_t item,
	output logic               item_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_sane
);
	import hues_pkg::*;

	logic      s1_valid_q;
	run_item_t s1_item_q;
	run_idx_t  idx_q;
	logic      out_valid_q;
	logic [7:0] out_byte_q;
	logic      out_last_q;
	logic      out_sane_q;

	logic out_load;
	logic s1_last;
	logic s1_free;
	logic take;

	// advance the run when the output register is free or draining
	assign out_load   = s1_valid_q && (!out_valid_q || !out_stall);
	assign s1_last    = (idx_q == run_len(s1_item_q.kind) - 3'd1);
	assign s1_free    = !s1_valid_q || (out_load && s1_last);
	assign take       = item_valid && s1_free;
	assign item_stall = !s1_free;

	// hold the item under expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
				idx_q      <= '0;
			end else if (out_load && s1_last) begin
				s1_valid_q <= 1'b0;
				idx_q      <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_item_q <= item;
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= run_char(s1_item_q.kind, s1_item_q.data, idx_q);
			out_last_q <= s1_last;
			out_sane_q <= s1_last && s1_item_q.eos && s1_item_q.sane;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = out_last_q;
	assign string_sane = out_sane_q;

endmodule

// File: rtl/html_url_escape_stream.sv
// ----------------------------------------------------------------------------
// html_url_escape_stream
// Streaming HTML attribute / entity / percent-url escaper with a per-string
// alphanumeric check.
// ----------------------------------------------------------------------------
// Each input beat expands into a run of output beats: 1 for a byte passed
// through, 3 for a percent escape, 6 for an &#xHH; escape. The output
// register issues one beat per cycle while out_stall is low, so plain
// bytes stream at one per cycle when unstalled. A byte is taken while the
// previous run drains, and its first beat passes the held-item register
// and then the output register. escape_mode is sampled when a byte is
// accepted; write it only while the block is idle.
module html_url_escape_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_sane
);
	import hues_pkg::*;

	logic [1:0] escape_mode_q;
	logic       clean_so_far_q;
	logic       alnum;
	logic       accept;
	run_item_t  item;

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_mode_q <= MODE_ATTR;
		end else if (cfg_wr_en) begin
			escape_mode_q <= cfg_wr_data;
		end
	end

	// classify the incoming byte
	assign alnum = is_alnum(in_byte);

	always_comb begin
		item.data = in_byte;
		item.eos  = end_of_string;
		item.sane = clean_so_far_q && alnum;
		case (escape_mode_q)
			MODE_URL:    item.kind = alnum ? KIND_PASS : KIND_URL;
			MODE_ENTITY: item.kind = is_html_special(in_byte) ? KIND_ENT : KIND_PASS;
			default:     item.kind = alnum ? KIND_PASS : KIND_ENT;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// track the string's alphanumeric check; restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clean_so_far_q <= 1'b1;
		end else if (accept) begin
			clean_so_far_q <= end_of_string ? 1'b1 : item.sane;
		end
	end

	hues_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (in_valid),
		.item        (item),
		.item_stall  (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_sane (string_sane)
	);

endmodule

// File: verif/html_url_escape_stream_tb.sv
// ----------------------------------------------------------------------------
// html_url_escape_stream_tb
// Self-checking bench for the escape stream. A short directed table covers
// every mode, the field extremes, the html specials, the zero and high bytes
// and the spare mode code. Random strings follow in several mode phases. Both
// handshakes idle at random, and every output beat is compared with a local
// escape predictor or, for typed rows, with the row's own expected beat.
// ----------------------------------------------------------------------------
module html_url_escape_stream_tb;

	import hues_pkg::*;

	// spare mode code, decodes as attribute escape
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int RAND_PHASES      = 8;
	localparam int ITEMS_PER_PHASE  = 35;
	localparam int DRAIN_CYCLES     = 6;

	// one expected output beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       sane;
	} esc_beat_t;

	// one directed stimulus row; typed rows carry their single expected beat
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       eos;
		logic       typed;
		logic [7:0] exp_byte;
		logic       exp_sane;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_string;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_sane;

	esc_beat_t  pending_beats[$];
	logic [1:0] cur_mode;
	logic       clean_flag;
	int         err_count;
	int         rx_hold;
	logic       rx_steady;
	logic       tx_steady;
	dir_row_t   dir_rows[20];

	html_url_escape_stream u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.string_sane  (string_sane)
	);

	// free-running clock
	always #10 clk = ~clk;

	// lower-case hex character of one nibble
	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + {4'b0000, n};
		return "a" + {4'b0000, n} - 8'd10;
	endfunction

	// expand one byte into its escaped run and advance the string flag
	function automatic int escape_run(input logic [7:0] b, input logic eos,
		output esc_beat_t run [6]);
		logic [7:0] chars [6];
		logic       alnum;
		logic       esc;
		logic       sane;
		int         n;
		alnum = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
			(b >= "a" && b <= "z");
		n = 0;
		if (cur_mode == MODE_URL) begin
			if (alnum) begin
				chars[0] = b;
				n = 1;
			end else begin
				chars[0] = CH_PCT;
				chars[1] = nibble_char(b[7:4]);
				chars[2] = nibble_char(b[3:0]);
				n = 3;
			end
		end else begin
			if (cur_mode == MODE_ENTITY)
				esc = (b == CH_AMP) || (b == CH_LT) || (b == CH_GT) ||
					(b == CH_QUOT) || (b == CH_APOS) || (b == CH_SLASH);
			else
				esc = !alnum;
			if (esc) begin
				chars[0] = CH_AMP;
				chars[1] = CH_HASH;
				chars[2] = CH_X;
				chars[3] = nibble_char(b[7:4]);
				chars[4] = nibble_char(b[3:0]);
				chars[5] = CH_SEMI;
				n = 6;
			end else begin
				chars[0] = b;
				n = 1;
			end
		end
		sane = clean_flag && alnum;
		for (int k = 0; k < 6; k++) begin
			run[k].data = (k < n) ? chars[k] : 8'h00;
			run[k].last = (k == n - 1);
			run[k].sane = (k == n - 1) && eos && sane;
		end
		clean_flag = eos ? 1'b1 : sane;
		return n;
	endfunction

	// random byte: alphanumeric, html special or anything
	function automatic logic [7:0] pick_byte(input logic alnum_only);
		int sel;
		sel = $urandom_range(0, 61);
		if (alnum_only || $urandom_range(0, 2) == 0) begin
			if (sel < 10)
				return "0" + sel[7:0];
			if (sel < 36)
				return "A" + sel[7:0] - 8'd10;
			return "a" + sel[7:0] - 8'd36;
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0:       return CH_AMP;
				1:       return CH_LT;
				2:       return CH_GT;
				3:       return CH_QUOT;
				4:       return CH_APOS;
				default: return CH_SLASH;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// drain the block, then write the mode register; called at a falling edge
	task automatic set_mode(input logic [1:0] m);
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_mode = m;
	endtask

	// offer one input beat, after a random gap unless tx_steady is set; called at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic eos,
		input logic typed, input logic [7:0] exp_byte, input logic exp_sane);
		esc_beat_t run [6];
		int        gap;
		int        n;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_string <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// beat taken: queue its expected run
		n = escape_run(b, eos, run);
		if (typed) begin
			pending_beats.push_back('{exp_byte, 1'b1, exp_sane});
		end else begin
			for (int k = 0; k < n; k++)
				pending_beats.push_back(run[k]);
		end
		@(negedge clk);
	endtask

	// output stall: hold for the drawn number of cycles before each beat
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		esc_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected output beat out_byte=%0h", out_byte);
				err_count++;
			end else begin
				want = pending_beats.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte expected %0h actual %0h", want.data, out_byte);
					err_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last expected %0b actual %0b", want.last, run_last);
					err_count++;
				end
				if (string_sane !== want.sane) begin
					$error("string_sane expected %0b actual %0b", want.sane, string_sane);
					err_count++;
				end
			end
			// draw the stall ahead of the next beat
			if ($urandom_range(0, 19) == 0)
				rx_steady = ~rx_steady;
			rx_hold = rx_steady ? 0 : $urandom_range(0, 5);
		end
	end

	// hard limit on run time
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int         count;
		int         len;
		logic       clean_str;
		logic [1:0] m;

		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = MODE_ATTR;
		in_valid      = 1'b0;
		in_byte       = 8'h00;
		end_of_string = 1'b0;
		cur_mode      = MODE_ATTR;
		clean_flag    = 1'b1;
		err_count     = 0;
		rx_hold       = 0;
		rx_steady     = 1'b0;
		tx_steady     = 1'b0;

		// directed rows: mode, byte, end, typed, expected byte, expected sane
		dir_rows = '{
			'{MODE_ATTR,   "A",      1'b0, 1'b1, "A",   1'b0},
			'{MODE_ATTR,   "z",      1'b1, 1'b1, "z",   1'b1},
			'{MODE_ATTR,   8'h00,    1'b1, 1'b0, 8'h00, 1'b0},
			'{MODE_ATTR,   8'hff,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ATTR,   "0",      1'b1, 1'b1, "0",   1'b0},
			'{MODE_ENTITY, CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, CH_LT,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, CH_GT,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, CH_QUOT,  1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, CH_APOS,  1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_ENTITY, "9",      1'b1, 1'b1, "9",   1'b0},
			'{MODE_ENTITY, 8'h00,    1'b1, 1'b1, 8'h00, 1'b0},
			'{MODE_ENTITY, "Z",      1'b1, 1'b1, "Z",   1'b1},
			'{MODE_ENTITY, 8'h80,    1'b1, 1'b1, 8'h80, 1'b0},
			'{MODE_URL,    8'h00,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_URL,    8'hff,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_URL,    "a",      1'b1, 1'b1, "a",   1'b0},
			'{MODE_SPARE,  8'h7f,    1'b0, 1'b0, 8'h00, 1'b0},
			'{MODE_SPARE,  "5",      1'b1, 1'b1, "5",   1'b0}
		};

		// hold reset, release on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, new mode written whenever a row changes it
		set_mode(dir_rows[0].mode);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != cur_mode)
				set_mode(dir_rows[i].mode);
			push_byte(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed,
				dir_rows[i].exp_byte, dir_rows[i].exp_sane);
		end

		// random strings, one mode per phase
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0:       m = MODE_URL;
				1:       m = MODE_ENTITY;
				2:       m = MODE_ATTR;
				3:       m = MODE_SPARE;
				default: m = 2'($urandom_range(0, 3));
			endcase
			set_mode(m);
			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				len       = $urandom_range(1, 8);
				clean_str = ($urandom_range(0, 2) == 0);
				tx_steady = ($urandom_range(0, 4) == 0);
				for (int j = 0; j < len; j++)
					push_byte(pick_byte(clean_str), j == len - 1, 1'b0, 8'h00, 1'b0);
				count += len;
			end
		end

		// drain and report
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
